// ===== rtl/mapemu_pkg.sv =====
// Shared types and constants for the memory access port emulator.
// Used by mapemu_ctrl, mapemu_dp and mem_access_port_emulator_top.
// No dependencies.
`default_nettype none

package mapemu_pkg;

    // Store and slot sizing. The store depth must be a power of two.
    localparam int MAX_EMU_APS  = 5;
    localparam int WINDOW_WORDS = 1024;
    localparam int IDX_W        = $clog2(WINDOW_WORDS);
    localparam int SLOT_W       = (MAX_EMU_APS > 1) ? $clog2(MAX_EMU_APS) : 1;

    // Port widths.
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMU_COUNT = 3'd0,
        CFG_EMU_AP_0  = 3'd1,
        CFG_EMU_AP_1  = 3'd2,
        CFG_EMU_AP_2  = 3'd3,
        CFG_EMU_AP_3  = 3'd4,
        CFG_EMU_AP_4  = 3'd5,
        CFG_AP_OFFSET = 3'd6
    } cfg_idx_t;

    localparam logic [15:0] AP_OFFSET_RESET = 16'h0100;

    // Access kinds.
    typedef enum logic [2:0] {
        MODE_AP_READ  = 3'd0,
        MODE_AP_WRITE = 3'd1,
        MODE_RUN      = 3'd2,
        MODE_DP_READ  = 3'd3,
        MODE_DP_WRITE = 3'd4
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_RD_ERR = 2'd1,
        STS_WR_ERR = 2'd2
    } status_t;

    // Emulated AP register offsets.
    localparam logic [7:0] REG_CSW  = 8'h00;
    localparam logic [7:0] REG_TAR  = 8'h04;
    localparam logic [7:0] REG_DRW  = 8'h0C;
    localparam logic [7:0] REG_BD0  = 8'h10;
    localparam logic [7:0] REG_BD1  = 8'h14;
    localparam logic [7:0] REG_BD2  = 8'h18;
    localparam logic [7:0] REG_BD3  = 8'h1C;
    localparam logic [7:0] REG_CFG  = 8'hF4;
    localparam logic [7:0] REG_BASE = 8'hF8;
    localparam logic [7:0] REG_IDR  = 8'hFC;

    // DP CTRL/STAT offset and its read value with both power-up acknowledges.
    localparam logic [7:0]  DP_REG_CTRLSTAT = 8'h04;
    localparam logic [31:0] PWRUP_ACKS      = 32'hA000_0000;

    localparam logic [2:0] CSW_SIZE_WORD = 3'd2;

    // Controller states.
    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2,
        S_DONE  = 2'd3
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic clear;
        logic load_in;
        logic exec;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/mapemu_ctrl.sv =====
// Sequencer for the memory access port emulator: clear pass, accept,
// execute and result hand-off. Depends on mapemu_pkg.
`default_nettype none

module mapemu_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire mapemu_pkg::ctrl_sts_t sts,
    output mapemu_pkg::ctrl_cmd_t      cmd
);

    mapemu_pkg::state_t state_reg;
    mapemu_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mapemu_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.clear    = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            mapemu_pkg::S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_last) begin
                    state_next = mapemu_pkg::S_IDLE;
                end
            end
            mapemu_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = mapemu_pkg::S_EXEC;
                end
            end
            mapemu_pkg::S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = mapemu_pkg::S_DONE;
            end
            mapemu_pkg::S_DONE: begin
                // The result moves to the output register and the next item
                // can be taken in the same cycle.
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    s_tready     = 1'b1;
                    if (s_tvalid) begin
                        cmd.load_in = 1'b1;
                        state_next  = mapemu_pkg::S_EXEC;
                    end else begin
                        state_next  = mapemu_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                state_next = mapemu_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mapemu_dp.sv =====
// Datapath of the memory access port emulator: configuration registers,
// per-slot TAR/CSW, sticky error, word store and result registers.
// Depends on mapemu_pkg.
`default_nettype none

module mapemu_dp (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [mapemu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mapemu_pkg::CFG_DAT_W-1:0]       cfg_wdata,
    input  wire logic [mapemu_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [mapemu_pkg::M_TDATA_W-1:0]            m_tdata,
    input  wire mapemu_pkg::ctrl_cmd_t                  cmd,
    output mapemu_pkg::ctrl_sts_t                       sts
);

    localparam int IDX_W  = mapemu_pkg::IDX_W;
    localparam int SLOT_W = mapemu_pkg::SLOT_W;
    localparam int NSLOT  = mapemu_pkg::MAX_EMU_APS;

    // Configuration.
    logic [2:0]  emu_count_reg;
    logic [7:0]  emu_ap_reg [NSLOT];
    logic [15:0] ap_offset_reg;

    // Access state.
    logic [31:0]         tar_reg [NSLOT];
    logic [31:0]         csw_reg [NSLOT];
    mapemu_pkg::status_t sticky_reg;
    mapemu_pkg::status_t sticky_next;

    // Accepted item.
    mapemu_pkg::mode_t in_mode_reg;
    logic [7:0]        in_apn_reg;
    logic [7:0]        in_off_reg;
    logic [31:0]       in_wdata_reg;

    // Store and its clearing pass.
    logic [31:0]      store_mem [mapemu_pkg::WINDOW_WORDS];
    logic [31:0]      mem_q_reg;
    logic [IDX_W-1:0] clr_cnt_reg;

    // Pending result and output register.
    logic [31:0]         res_rdata_reg;
    logic [31:0]         res_rdata_next;
    mapemu_pkg::status_t res_status_reg;
    mapemu_pkg::status_t res_status_next;
    logic                res_direct_reg;
    logic                res_direct_next;
    logic [23:0]         res_doff_reg;
    logic [23:0]         res_doff_next;
    logic                res_from_mem_reg;
    logic                m_tvalid_reg;
    logic [63:0]         m_tdata_reg;

    // Decode.
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       cur_tar;
    logic [31:0]       cur_csw;
    logic              acc_we;
    logic              acc_re;
    logic [IDX_W-1:0]  acc_idx;
    logic              tar_we;
    logic [31:0]       tar_next;
    logic              csw_we;
    logic [31:0]       csw_next;
    logic [23:0]       doff_prod;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [31:0]       mem_wdata;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emu_count_reg <= '0;
            for (int i = 0; i < NSLOT; i++) begin
                emu_ap_reg[i] <= '0;
            end
            ap_offset_reg <= mapemu_pkg::AP_OFFSET_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mapemu_pkg::CFG_EMU_COUNT: emu_count_reg <= cfg_wdata[2:0];
                mapemu_pkg::CFG_AP_OFFSET: ap_offset_reg <= cfg_wdata;
                default: begin
                    if (cfg_index >= mapemu_pkg::CFG_EMU_AP_0 &&
                        cfg_index <= mapemu_pkg::CFG_EMU_AP_4 &&
                        int'(cfg_index - mapemu_pkg::CFG_EMU_AP_0) < NSLOT) begin
                        emu_ap_reg[SLOT_W'(cfg_index - mapemu_pkg::CFG_EMU_AP_0)]
                            <= cfg_wdata[7:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_mode_reg  <= mapemu_pkg::mode_t'(s_tdata[2:0]);
            in_apn_reg   <= s_tdata[10:3];
            in_off_reg   <= s_tdata[18:11];
            in_wdata_reg <= s_tdata[50:19];
        end
    end

    // Slot search: the lowest enabled slot with a matching AP number wins.
    always_comb begin
        hit  = 1'b0;
        slot = '0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (i < int'(emu_count_reg) && emu_ap_reg[i] == in_apn_reg) begin
                hit  = 1'b1;
                slot = SLOT_W'(i);
            end
        end
    end

    assign cur_tar   = tar_reg[slot];
    assign cur_csw   = csw_reg[slot];
    assign doff_prod = 24'(ap_offset_reg) * 24'(in_apn_reg);

    always_comb begin
        acc_we          = 1'b0;
        acc_re          = 1'b0;
        acc_idx         = cur_tar[IDX_W+1:2];
        tar_we          = 1'b0;
        tar_next        = cur_tar;
        csw_we          = 1'b0;
        csw_next        = {in_wdata_reg[31:3], mapemu_pkg::CSW_SIZE_WORD};
        sticky_next     = sticky_reg;
        res_rdata_next  = '0;
        res_status_next = mapemu_pkg::STS_OK;
        res_direct_next = 1'b0;
        res_doff_next   = '0;
        case (in_mode_reg)
            mapemu_pkg::MODE_AP_READ, mapemu_pkg::MODE_AP_WRITE: begin
                if (!hit) begin
                    res_direct_next = 1'b1;
                    res_doff_next   = doff_prod + 24'(in_off_reg);
                end else begin
                    case (in_off_reg)
                        mapemu_pkg::REG_CSW: begin
                            csw_we         = (in_mode_reg == mapemu_pkg::MODE_AP_WRITE);
                            res_rdata_next = csw_we ? 32'd0 : cur_csw;
                        end
                        mapemu_pkg::REG_TAR: begin
                            tar_we         = (in_mode_reg == mapemu_pkg::MODE_AP_WRITE);
                            tar_next       = {in_wdata_reg[31:2], 2'b00};
                            res_rdata_next = tar_we ? 32'd0 : cur_tar;
                        end
                        mapemu_pkg::REG_CFG, mapemu_pkg::REG_BASE,
                        mapemu_pkg::REG_IDR: begin
                        end
                        mapemu_pkg::REG_BD0, mapemu_pkg::REG_BD1,
                        mapemu_pkg::REG_BD2, mapemu_pkg::REG_BD3: begin
                            // Banked word: TAR aligned to 16 bytes plus 4n.
                            acc_idx = {cur_tar[IDX_W+1:4], in_off_reg[3:2]};
                            acc_we  = (in_mode_reg == mapemu_pkg::MODE_AP_WRITE);
                            acc_re  = !acc_we;
                        end
                        mapemu_pkg::REG_DRW: begin
                            acc_we   = (in_mode_reg == mapemu_pkg::MODE_AP_WRITE);
                            acc_re   = !acc_we;
                            tar_we   = (cur_csw[5:4] != 2'b00);
                            tar_next = cur_tar + 32'd4;
                        end
                        default: begin
                            res_status_next = (in_mode_reg == mapemu_pkg::MODE_AP_WRITE)
                                            ? mapemu_pkg::STS_WR_ERR
                                            : mapemu_pkg::STS_RD_ERR;
                            sticky_next     = res_status_next;
                        end
                    endcase
                end
            end
            mapemu_pkg::MODE_RUN: begin
                res_status_next = sticky_reg;
                sticky_next     = mapemu_pkg::STS_OK;
            end
            mapemu_pkg::MODE_DP_READ: begin
                res_rdata_next = (in_off_reg == mapemu_pkg::DP_REG_CTRLSTAT)
                               ? mapemu_pkg::PWRUP_ACKS : 32'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSLOT; i++) begin
                tar_reg[i] <= '0;
                csw_reg[i] <= '0;
            end
            sticky_reg <= mapemu_pkg::STS_OK;
        end else if (cmd.exec) begin
            if (tar_we) begin
                tar_reg[slot] <= tar_next;
            end
            if (csw_we) begin
                csw_reg[slot] <= csw_next;
            end
            sticky_reg <= sticky_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_rdata_reg    <= res_rdata_next;
            res_status_reg   <= res_status_next;
            res_direct_reg   <= res_direct_next;
            res_doff_reg     <= res_doff_next;
            res_from_mem_reg <= acc_re;
        end
    end

    // One write port shared by the clearing pass and store writes.
    assign mem_we    = cmd.clear || (cmd.exec && acc_we);
    assign mem_waddr = cmd.clear ? clr_cnt_reg : acc_idx;
    assign mem_wdata = cmd.clear ? 32'd0 : in_wdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.exec && acc_re) begin
            mem_q_reg <= store_mem[acc_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == {IDX_W{1'b1}});
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {5'd0, res_doff_reg, res_direct_reg, res_status_reg,
                            res_from_mem_reg ? mem_q_reg : res_rdata_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The clearing pass owns the store: no item is taken or executed during it.
    a_clear_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !(cmd.load_in || cmd.exec || cmd.load_out))
        else $error("item activity during store clearing pass");

    // A result is only moved out when the output register can take it.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over an untaken output");

    // Each item executes for exactly one cycle.
    a_exec_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> !cmd.exec)
        else $error("execute held for more than one cycle");

    // An accepted item is executed in the following cycle.
    a_load_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> cmd.exec)
        else $error("accepted item not executed");

endmodule

`default_nettype wire

// ===== rtl/mem_access_port_emulator_top.sv =====
// Top level of the memory access port emulator: joins the sequencer and the
// datapath. Depends on mapemu_pkg, mapemu_ctrl and mapemu_dp.
//
//   channel   direction  ports                         payload
//   s_        in         s_tvalid s_tready s_tdata     one debug access
//   m_        out        m_tvalid m_tready m_tdata     one result per access
//   cfg_      in         cfg_wr_en cfg_index cfg_wdata register write, no wait
//
// An access is captured into the input registers and then executed against the
// TAR/CSW registers and the single-port word store; the result is handed
// to the output register as the next access is captured.
// After reset a clearing pass writes zero to each of the 1024 store words, one
// per cycle; s_tready stays low meanwhile, configuration writes work.
// A stalled output holds one result; the next access waits until it is taken.
`default_nettype none

module mem_access_port_emulator_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // mode[2:0], ap_number[10:3], reg_offset[18:11], wdata[50:19], zero[55:51]
    input  wire logic [mapemu_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // rdata[31:0], status[33:32], direct[34], direct_offset[58:35], zero[63:59]
    output logic [mapemu_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mapemu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mapemu_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

    mapemu_pkg::ctrl_cmd_t cmd;
    mapemu_pkg::ctrl_sts_t sts;

    mapemu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mapemu_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== verif/mem_access_port_emulator_top_tb.sv =====
// Self-checking testbench for mem_access_port_emulator_top: predicts every debug access
// result in a scoreboard class and drives both stream channels with random idle cycles.
// Depends on mapemu_pkg and the RTL of mem_access_port_emulator_top.
`default_nettype none

module mem_access_port_emulator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mapemu_pkg::*;

    localparam logic [2:0]  MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0]  MODE_UNUSED_HI = 3'd7;
    localparam logic [2:0]  CFG_SPARE_IDX  = 3'd7;
    localparam logic [7:0]  REG_RESERVED   = 8'h08;
    localparam logic [7:0]  DP_SELECT      = 8'h08;
    localparam logic [7:0]  BD_SELECT      = 8'h0C;
    localparam logic [31:0] CSW_SIZE_BITS  = 32'h0000_0007;
    localparam logic [31:0] TAR_ALIGN_MASK = 32'h0000_0003;
    localparam logic [31:0] BANK_MASK      = 32'h0000_000F;
    localparam logic [31:0] ADDR_TOP_BIT   = 32'h8000_0000;
    localparam logic [31:0] TAR_STEP       = 32'd4;

    typedef struct {
        logic [31:0] rdata;
        logic [1:0]  status;
        logic        direct;
        logic [23:0] direct_offset;
    } ap_result_t;

    class ap_emu_scoreboard;
        logic [2:0]  emu_count;
        logic [7:0]  emu_ap[MAX_EMU_APS];
        logic [15:0] ap_offset;
        logic [31:0] tar[MAX_EMU_APS];
        logic [31:0] csw[MAX_EMU_APS];
        logic [1:0]  sticky;
        logic [31:0] store_words[WINDOW_WORDS];
        ap_result_t  pending_results[$];
        int          fail_count;

        function new();
            emu_count = '0;
            ap_offset = AP_OFFSET_RESET;
            sticky = STS_OK;
            fail_count = 0;
            for (int i = 0; i < MAX_EMU_APS; i++) begin
                emu_ap[i] = '0;
                tar[i] = '0;
                csw[i] = '0;
            end
            for (int i = 0; i < WINDOW_WORDS; i++) begin
                store_words[i] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] v);
            case (idx)
                CFG_EMU_COUNT: emu_count = v[2:0];
                CFG_AP_OFFSET: ap_offset = v;
                default: begin
                    if (idx >= CFG_EMU_AP_0 && idx <= CFG_EMU_AP_4)
                        emu_ap[idx - CFG_EMU_AP_0] = v[7:0];
                end
            endcase
        endfunction

        // Counts above the slot count behave as the slot count; the lowest slot wins.
        function int find_slot(logic [7:0] apn);
            int n;
            n = (emu_count > MAX_EMU_APS) ? MAX_EMU_APS : emu_count;
            for (int i = 0; i < n; i++) begin
                if (emu_ap[i] == apn)
                    return i;
            end
            return -1;
        endfunction

        function void emulate(int slot, bit wr, logic [7:0] offs, logic [31:0] wd,
                              inout ap_result_t r);
            logic [31:0] addr;
            int          word;
            case (offs)
                REG_CSW: begin
                    if (wr)
                        csw[slot] = (wd & ~CSW_SIZE_BITS) | 32'(CSW_SIZE_WORD);
                    else
                        r.rdata = csw[slot];
                end
                REG_TAR: begin
                    if (wr)
                        tar[slot] = wd & ~TAR_ALIGN_MASK;
                    else
                        r.rdata = tar[slot];
                end
                REG_CFG, REG_BASE, REG_IDR: ;
                REG_DRW, REG_BD0, REG_BD1, REG_BD2, REG_BD3: begin
                    if (offs == REG_DRW)
                        addr = tar[slot];
                    else
                        addr = (tar[slot] & ~BANK_MASK) + 32'(offs & BD_SELECT);
                    word = int'(((addr & ~ADDR_TOP_BIT) >> 2) % WINDOW_WORDS);
                    if (wr)
                        store_words[word] = wd;
                    else
                        r.rdata = store_words[word];
                    if (offs == REG_DRW && csw[slot][5:4] != 2'b00)
                        tar[slot] = tar[slot] + TAR_STEP;
                end
                default: begin
                    sticky = wr ? STS_WR_ERR : STS_RD_ERR;
                    r.status = sticky;
                end
            endcase
        endfunction

        function void note_access(logic [2:0] m, logic [7:0] apn, logic [7:0] offs,
                                  logic [31:0] wd);
            ap_result_t  r;
            int          slot;
            logic [31:0] full_offset;
            r.rdata = '0;
            r.status = STS_OK;
            r.direct = 1'b0;
            r.direct_offset = '0;
            if (m == MODE_AP_READ || m == MODE_AP_WRITE) begin
                slot = find_slot(apn);
                if (slot < 0) begin
                    full_offset = 32'(ap_offset) * 32'(apn) + 32'(offs);
                    r.direct = 1'b1;
                    r.direct_offset = full_offset[23:0];
                end else begin
                    emulate(slot, m == MODE_AP_WRITE, offs, wd, r);
                end
            end else if (m == MODE_RUN) begin
                r.status = sticky;
                sticky = STS_OK;
            end else if (m == MODE_DP_READ) begin
                r.rdata = (offs == DP_REG_CTRLSTAT) ? PWRUP_ACKS : '0;
            end
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            ap_result_t want;
            if (pending_results.size() == 0) begin
                $error("result transfer with no access outstanding: %h", beat);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("rdata", want.rdata, beat[31:0]);
            compare_field("status", 32'(want.status), 32'(beat[33:32]));
            compare_field("direct", 32'(want.direct), 32'(beat[34]));
            compare_field("direct_offset", 32'(want.direct_offset), 32'(beat[58:35]));
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DAT_W-1:0]   cfg_wdata = '0;

    bit send_steady = 1'b0;
    bit take_steady = 1'b0;

    ap_emu_scoreboard sb = new();

    mem_access_port_emulator_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.write_reg(idx, v);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_access(input logic [2:0] m, input logic [7:0] apn,
                               input logic [7:0] offs, input logic [31:0] wd);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, wd, offs, apn, m};
        do @(posedge aclk); while (!s_tready);
        sb.note_access(m, apn, offs, wd);
    endtask

    // Holds off the sender until every outstanding result transfer has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure_phase(input int ph);
        logic [2:0] counts[8] = '{3'd5, 3'd1, 3'd7, 3'd0, 3'd2, 3'd6, 3'd4, 3'd3};
        int         sel;
        logic [7:0] apv;
        logic [15:0] stride;
        write_cfg(CFG_EMU_COUNT, 16'(counts[ph % 8]));
        for (int k = 0; k < MAX_EMU_APS; k++) begin
            sel = $urandom_range(0, 5);
            if (sel == 0)
                apv = 8'h00;
            else if (sel == 1)
                apv = 8'hFF;
            else if (sel == 2 && k > 0)
                apv = sb.emu_ap[0];
            else
                apv = 8'($urandom_range(0, 255));
            write_cfg(CFG_IDX_W'(CFG_EMU_AP_0 + k), 16'(apv));
        end
        if (ph == 0)
            stride = 16'hFFFF;
        else if (ph == 1)
            stride = 16'h0000;
        else if (ph == 3)
            stride = AP_OFFSET_RESET;
        else
            stride = 16'($urandom_range(0, 65535));
        write_cfg(CFG_AP_OFFSET, stride);
        if (ph == 2)
            write_cfg(CFG_SPARE_IDX, 16'($urandom_range(0, 65535)));
    endtask

    // Mostly accesses to configured slots through known registers, so TAR, CSW and
    // the store are exercised in depth; the rest is noise.
    task automatic send_random(input int count);
        logic [7:0] known_regs[10] = '{REG_CSW, REG_TAR, REG_DRW, REG_BD0, REG_BD1,
                                        REG_BD2, REG_BD3, REG_CFG, REG_BASE, REG_IDR};
        int          pick;
        logic [2:0]  m;
        logic [7:0]  apn;
        logic [7:0]  offs;
        logic [31:0] wd;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                m = MODE_AP_READ;
            else if (pick < 76)
                m = MODE_AP_WRITE;
            else if (pick < 84)
                m = MODE_RUN;
            else if (pick < 91)
                m = MODE_DP_READ;
            else if (pick < 97)
                m = MODE_DP_WRITE;
            else
                m = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));

            if ($urandom_range(0, 99) < 80)
                apn = sb.emu_ap[$urandom_range(0, MAX_EMU_APS - 1)];
            else
                apn = 8'($urandom_range(0, 255));

            pick = $urandom_range(0, 99);
            if (pick < 12)
                offs = 8'($urandom_range(0, 255));
            else if (pick < 32)
                offs = REG_DRW;
            else
                offs = known_regs[$urandom_range(0, 9)];
            if (m == MODE_DP_READ && $urandom_range(0, 1) == 1)
                offs = DP_REG_CTRLSTAT;

            wd = $urandom;
            // Keep most TAR values in a small region so stored words are read back.
            if (offs == REG_TAR && $urandom_range(0, 3) != 0)
                wd = (wd & (ADDR_TOP_BIT | 32'h0000_007F));
            send_access(m, apn, offs, wd);
        end
    endtask

    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            int stall;
            stall = take_steady ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial begin
        #2_000_000;
        $display("mem_access_port_emulator_top regression: fail");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Slot two duplicates slot zero; slots three and four lie beyond the count.
        write_cfg(CFG_EMU_COUNT, 16'd3);
        write_cfg(CFG_EMU_AP_0, 16'h00);
        write_cfg(CFG_EMU_AP_1, 16'hFF);
        write_cfg(CFG_EMU_AP_2, 16'h00);
        write_cfg(CFG_EMU_AP_3, 16'h42);
        write_cfg(CFG_EMU_AP_4, 16'h99);

        send_access(MODE_DP_READ, 8'h00, DP_REG_CTRLSTAT, 32'h0);
        send_access(MODE_DP_READ, 8'h00, DP_SELECT, 32'h0);
        send_access(MODE_DP_WRITE, 8'hFF, DP_SELECT, 32'hFFFF_FFFF);
        send_access(MODE_AP_WRITE, 8'h00, REG_CSW, 32'hFFFF_FFFF);
        send_access(MODE_AP_READ, 8'h00, REG_CSW, 32'h0);
        send_access(MODE_AP_WRITE, 8'h00, REG_TAR, 32'hFFFF_FFFF);
        send_access(MODE_AP_READ, 8'h00, REG_TAR, 32'h0);
        // TAR wraps past the top of the 32-bit space after this transfer.
        send_access(MODE_AP_WRITE, 8'h00, REG_DRW, 32'hDEAD_BEEF);
        send_access(MODE_AP_READ, 8'h00, REG_TAR, 32'h0);
        send_access(MODE_AP_READ, 8'h00, REG_DRW, 32'h0);
        send_access(MODE_AP_WRITE, 8'hFF, REG_TAR, 32'h8000_0FF7);
        send_access(MODE_AP_WRITE, 8'hFF, REG_BD0, 32'h1111_1111);
        send_access(MODE_AP_WRITE, 8'hFF, REG_BD1, 32'h2222_2222);
        send_access(MODE_AP_WRITE, 8'hFF, REG_BD2, 32'h4444_4444);
        send_access(MODE_AP_WRITE, 8'hFF, REG_BD3, 32'h8888_8888);
        send_access(MODE_AP_READ, 8'hFF, REG_DRW, 32'h0);
        send_access(MODE_AP_READ, 8'hFF, REG_BD3, 32'h0);
        send_access(MODE_AP_READ, 8'hFF, REG_IDR, 32'h0);
        send_access(MODE_AP_WRITE, 8'hFF, REG_CFG, 32'hFFFF_FFFF);
        send_access(MODE_AP_READ, 8'h00, REG_BASE, 32'h0);
        send_access(MODE_AP_READ, 8'h00, REG_RESERVED, 32'h0);
        send_access(MODE_AP_WRITE, 8'hFF, REG_RESERVED, 32'h1234_5678);
        send_access(MODE_RUN, 8'h00, 8'h00, 32'h0);
        send_access(MODE_RUN, 8'h00, 8'h00, 32'h0);
        send_access(MODE_AP_READ, 8'h42, REG_DRW, 32'h0);
        send_access(MODE_AP_WRITE, 8'h99, 8'hFF, 32'hFFFF_FFFF);
        send_access(MODE_UNUSED_LO, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_access(MODE_UNUSED_HI, 8'h00, REG_TAR, 32'h0);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            configure_phase(ph);
            send_steady = (ph % 3 == 1);
            take_steady = (ph % 4 == 2);
            send_random(103);
            wait_drained();
        end

        repeat (16) @(posedge aclk);
        if (sb.fail_count == 0 && sb.pending_results.size() == 0) begin
            $display("mem_access_port_emulator_top regression: pass");
        end else begin
            $display("mem_access_port_emulator_top regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/mapemu_pkg.sv
rtl/mapemu_ctrl.sv
rtl/mapemu_dp.sv
rtl/mem_access_port_emulator_top.sv
verif/mem_access_port_emulator_top_tb.sv
